// ===== rtl/bdq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared sizes, codes and inter-module structs of the bounded deque buffer.
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int DEPTH  = 32;
   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = PTR_W + 1;
   localparam int DATA_W = 32;
   localparam int ACT_W  = 3;
   localparam int STAT_W = 2;

   localparam logic [DATA_W-1:0] VALUE_NONE = '1;

   typedef enum logic [ACT_W-1:0] {
      ACT_EMPTY_QUERY = 3'd0,
      ACT_PEEK_FRONT  = 3'd1,
      ACT_POP_FRONT   = 3'd2,
      ACT_PUSH_FRONT  = 3'd3,
      ACT_DUMP_ALL    = 3'd4,
      ACT_PUSH_BACK   = 3'd5
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DUMP
   } state_type;

   // command to the entry memory: one access per cycle
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [PTR_W-1:0]  addr;
      logic [DATA_W-1:0] wdata;
   } mem_cmd_type;

   // result handed to the output register
   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] value;
      status_type        status;
      logic              last;
   } rsp_load_type;

endpackage

// ===== rtl/bdq_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_mem
// Ring of deque entries: single-port synchronous memory, registered read.
// ----------------------------------------------------------------------------
module bdq_mem (
   input  logic                       clock,
   input  bdq_pkg::mem_cmd_type       mem_cmd,
   output logic [bdq_pkg::DATA_W-1:0] rd_data
);

   logic [bdq_pkg::DATA_W-1:0] entry_mem [bdq_pkg::DEPTH];
   logic [bdq_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         entry_mem[mem_cmd.addr] <= mem_cmd.wdata;
      end
   end

   // hold the last read word until the next read
   always_ff @(posedge clock) begin
      if (mem_cmd.rd_en) begin
         rd_data_ff <= entry_mem[mem_cmd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bdq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_ctrl
// Action decoder and sequencer: ring pointers, memory commands, dump walk.
// ----------------------------------------------------------------------------
module bdq_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [bdq_pkg::ACT_W-1:0]  req_action,
   input  logic [bdq_pkg::DATA_W-1:0] req_value,
   input  logic                       out_free,
   output bdq_pkg::mem_cmd_type       mem_cmd,
   input  logic [bdq_pkg::DATA_W-1:0] rd_data,
   output bdq_pkg::rsp_load_type      rsp_load
);

   localparam int PTR_W = bdq_pkg::PTR_W;
   localparam int CNT_W = bdq_pkg::CNT_W;
   localparam int SUM_W = bdq_pkg::SUM_W;

   bdq_pkg::state_type state_ff, state_in;
   logic [PTR_W-1:0]   fp_ff, fp_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   remain_ff, remain_in;
   logic [PTR_W-1:0]   idx_ff, idx_in;
   logic               pop_ff, pop_in;

   logic               accept;
   logic               is_empty;
   logic               is_full;
   logic [PTR_W-1:0]   fp_next;
   logic [PTR_W-1:0]   fp_prev;
   logic [PTR_W-1:0]   idx_next;
   logic [SUM_W-1:0]   back_sum;
   logic [PTR_W-1:0]   back_idx;
   logic               dump_last;

   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CNT_W'(bdq_pkg::DEPTH));
   assign fp_next   = (fp_ff == PTR_W'(bdq_pkg::DEPTH - 1)) ? '0 : fp_ff + 1'b1;
   assign fp_prev   = (fp_ff == '0) ? PTR_W'(bdq_pkg::DEPTH - 1) : fp_ff - 1'b1;
   assign idx_next  = (idx_ff == PTR_W'(bdq_pkg::DEPTH - 1)) ? '0 : idx_ff + 1'b1;
   assign back_sum  = SUM_W'(fp_ff) + SUM_W'(count_ff);
   assign back_idx  = (back_sum >= SUM_W'(bdq_pkg::DEPTH))
                      ? PTR_W'(back_sum - SUM_W'(bdq_pkg::DEPTH))
                      : PTR_W'(back_sum);
   assign dump_last = (remain_ff == CNT_W'(1));

   assign req_ready = (state_ff == bdq_pkg::ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bdq_pkg::ST_IDLE: begin
            if (accept && !is_empty) begin
               case (req_action)
                  bdq_pkg::ACT_PEEK_FRONT,
                  bdq_pkg::ACT_POP_FRONT: state_in = bdq_pkg::ST_READ;
                  bdq_pkg::ACT_DUMP_ALL:  state_in = bdq_pkg::ST_DUMP;
                  default:                state_in = bdq_pkg::ST_IDLE;
               endcase
            end
         end
         bdq_pkg::ST_READ: begin
            if (out_free) begin
               state_in = bdq_pkg::ST_IDLE;
            end
         end
         bdq_pkg::ST_DUMP: begin
            if (out_free && dump_last) begin
               state_in = bdq_pkg::ST_IDLE;
            end
         end
         default: state_in = bdq_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      mem_cmd         = '0;
      rsp_load        = '0;
      rsp_load.status = bdq_pkg::STAT_OK;
      rsp_load.last   = 1'b1;
      fp_in           = fp_ff;
      count_in        = count_ff;
      remain_in       = remain_ff;
      idx_in          = idx_ff;
      pop_in          = pop_ff;
      case (state_ff)
         bdq_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  bdq_pkg::ACT_EMPTY_QUERY: begin
                     rsp_load.valid = 1'b1;
                     rsp_load.value = bdq_pkg::DATA_W'(is_empty);
                  end
                  bdq_pkg::ACT_PEEK_FRONT,
                  bdq_pkg::ACT_POP_FRONT,
                  bdq_pkg::ACT_DUMP_ALL: begin
                     if (is_empty) begin
                        rsp_load.valid  = 1'b1;
                        rsp_load.value  = bdq_pkg::VALUE_NONE;
                        rsp_load.status = bdq_pkg::STAT_EMPTY;
                     end else begin
                        mem_cmd.rd_en = 1'b1;
                        mem_cmd.addr  = fp_ff;
                        pop_in        = (req_action == bdq_pkg::ACT_POP_FRONT);
                        remain_in     = count_ff;
                        idx_in        = fp_next;
                     end
                  end
                  bdq_pkg::ACT_PUSH_FRONT,
                  bdq_pkg::ACT_PUSH_BACK: begin
                     if (is_full) begin
                        rsp_load.valid  = 1'b1;
                        rsp_load.status = bdq_pkg::STAT_FULL;
                     end else begin
                        mem_cmd.wr_en = 1'b1;
                        mem_cmd.wdata = req_value;
                        count_in      = count_ff + 1'b1;
                        if (req_action == bdq_pkg::ACT_PUSH_FRONT) begin
                           mem_cmd.addr = fp_prev;
                           fp_in        = fp_prev;
                        end else begin
                           mem_cmd.addr = back_idx;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         bdq_pkg::ST_READ: begin
            if (out_free) begin
               rsp_load.valid = 1'b1;
               rsp_load.value = rd_data;
               if (pop_ff) begin
                  fp_in    = fp_next;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         bdq_pkg::ST_DUMP: begin
            if (out_free) begin
               rsp_load.valid = 1'b1;
               rsp_load.value = rd_data;
               rsp_load.last  = dump_last;
               if (!dump_last) begin
                  mem_cmd.rd_en = 1'b1;
                  mem_cmd.addr  = idx_ff;
                  idx_in        = idx_next;
                  remain_in     = remain_ff - 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bdq_pkg::ST_IDLE;
         fp_ff    <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         fp_ff    <= fp_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      remain_ff <= remain_in;
      idx_ff    <= idx_in;
      pop_ff    <= pop_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(bdq_pkg::DEPTH))
      else $error("entry count beyond depth");

   a_dump_remain: assert property (@(posedge clock) disable iff (reset)
      state_ff == bdq_pkg::ST_DUMP |-> remain_ff != '0)
      else $error("dump walk with nothing left");

   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_cmd.wr_en && mem_cmd.rd_en))
      else $error("read and write in one cycle");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load.valid |-> out_free)
      else $error("result loaded into an occupied output register");

   a_read_follows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bdq_pkg::ST_READ) && !$past(reset) |-> $past(mem_cmd.rd_en))
      else $error("read state without a preceding memory read");

endmodule

// ===== rtl/bounded_deque_buffer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_buffer_unit
// Bounded double-ended queue of 32-bit signed values held in a memory ring.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one transfer per action; tuser carries the action code,
//   tdata the value for the push actions. rsp_ channel: one transfer per
//   result; tdata carries the value, tuser the status, tlast marks the final
//   result of an action. A successful push and the unused codes six and seven
//   give no result.
// Sequencing:
//   Empty query, pushes and the empty/full answers need no memory read; a new
//   action may follow in the next cycle while the receiver keeps up, and the
//   result shows in the cycle after acceptance. Peek and pop go through one
//   memory read, then the result. A dump of n entries does one memory read
//   per entry, streaming one result per cycle while the receiver keeps up.
//   All reads and writes share the single memory port.
// Reset:
//   Synchronous, active high; the deque becomes empty with the front at
//   entry zero. Memory contents are not cleared, there is no clearing pass.
// Stalls:
//   The result waits in the output register; the next action is taken only
//   once that register is free or being drained, so no result is lost.
// ----------------------------------------------------------------------------
module bounded_deque_buffer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [31:0] push_value
   input  logic [2:0]  req_tuser,  // [2:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [31:0] result_value
   output logic [1:0]  rsp_tuser,  // [1:0] status
   output logic        rsp_tlast
);

   bdq_pkg::mem_cmd_type       mem_cmd;
   bdq_pkg::rsp_load_type      rsp_load;
   logic [bdq_pkg::DATA_W-1:0] rd_data;
   logic                       out_free;

   // output register
   logic                       rsp_valid_ff;
   logic [bdq_pkg::DATA_W-1:0] rsp_value_ff;
   bdq_pkg::status_type        rsp_status_ff;
   logic                       rsp_last_ff;

   // free when empty or being drained in this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   bdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_action (req_tuser),
      .req_value  (req_tdata),
      .out_free   (out_free),
      .mem_cmd    (mem_cmd),
      .rd_data    (rd_data),
      .rsp_load   (rsp_load)
   );

   bdq_mem u_mem (
      .clock   (clock),
      .mem_cmd (mem_cmd),
      .rd_data (rd_data)
   );

   // hold the result until the receiver takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load.valid) begin
         rsp_value_ff  <= rsp_load.value;
         rsp_status_ff <= rsp_load.status;
         rsp_last_ff   <= rsp_load.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bounded deque buffer: a shadow deque predicts
// every result of each accepted action, and each returned transfer is matched
// against the oldest prediction while both channels idle at random.
// ----------------------------------------------------------------------------
module tb;

   // the two codes the block must ignore
   localparam logic [bdq_pkg::ACT_W-1:0] ACT_SPARE_LO = 3'd6;
   localparam logic [bdq_pkg::ACT_W-1:0] ACT_SPARE_HI = 3'd7;

   localparam int unsigned HOLD_CYCLES   = 300;      // long receiver hold-off
   localparam int unsigned SETTLE_CYCLES = bdq_pkg::DEPTH + 8; // longest dump plus margin
   localparam int unsigned MAX_REPORTS   = 10;

   typedef enum {MIX_BALANCED, MIX_FILLING, MIX_DRAINING} mix_type;

   // -------------------------------------------------------------------------
   // Shadow deque: tracks contents and queues the results each action causes
   // -------------------------------------------------------------------------
   class deque_scoreboard;
      typedef struct packed {
         logic [bdq_pkg::DATA_W-1:0] value;
         bdq_pkg::status_type        status;
         logic                       last;
      } rsp_beat_type;

      logic [bdq_pkg::DATA_W-1:0] ring [bdq_pkg::DEPTH];
      int unsigned       head;
      int unsigned       fill;
      rsp_beat_type      pending [$];
      int unsigned       mismatches;
      int unsigned       actions_seen;
      int unsigned       results_seen;
      int unsigned       dumps;
      int unsigned       empty_answers;
      int unsigned       full_answers;

      function void queue_result(logic [bdq_pkg::DATA_W-1:0] v, bdq_pkg::status_type s,
                                 logic l);
         rsp_beat_type beat;
         beat.value  = v;
         beat.status = s;
         beat.last   = l;
         pending.push_back(beat);
      endfunction

      function void note_action(logic [bdq_pkg::ACT_W-1:0] act,
                                logic [bdq_pkg::DATA_W-1:0] v);
         int unsigned slot;
         actions_seen++;
         case (act)
            bdq_pkg::ACT_EMPTY_QUERY: begin
               queue_result((fill == 0) ? 32'd1 : 32'd0, bdq_pkg::STAT_OK, 1'b1);
            end
            bdq_pkg::ACT_PEEK_FRONT, bdq_pkg::ACT_POP_FRONT: begin
               if (fill == 0) begin
                  queue_result(bdq_pkg::VALUE_NONE, bdq_pkg::STAT_EMPTY, 1'b1);
                  empty_answers++;
               end else begin
                  queue_result(ring[head], bdq_pkg::STAT_OK, 1'b1);
                  if (act == bdq_pkg::ACT_POP_FRONT) begin
                     head = (head + 1) % bdq_pkg::DEPTH;
                     fill--;
                  end
               end
            end
            bdq_pkg::ACT_PUSH_FRONT, bdq_pkg::ACT_PUSH_BACK: begin
               if (fill == bdq_pkg::DEPTH) begin
                  queue_result('0, bdq_pkg::STAT_FULL, 1'b1);
                  full_answers++;
               end else begin
                  if (act == bdq_pkg::ACT_PUSH_FRONT) begin
                     head = (head + bdq_pkg::DEPTH - 1) % bdq_pkg::DEPTH;
                     slot = head;
                  end else begin
                     slot = (head + fill) % bdq_pkg::DEPTH;
                  end
                  ring[slot] = v;
                  fill++;
               end
            end
            bdq_pkg::ACT_DUMP_ALL: begin
               dumps++;
               if (fill == 0) begin
                  queue_result(bdq_pkg::VALUE_NONE, bdq_pkg::STAT_EMPTY, 1'b1);
                  empty_answers++;
               end else begin
                  for (int k = 0; k < fill; k++)
                     queue_result(ring[(head + k) % bdq_pkg::DEPTH], bdq_pkg::STAT_OK,
                                  (k + 1 == fill));
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic [bdq_pkg::DATA_W-1:0] v,
                                 logic [bdq_pkg::STAT_W-1:0] s, logic l);
         rsp_beat_type want;
         results_seen++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result: value %h status %0d last %0b", v, s, l);
            return;
         end
         want = pending.pop_front();
         if (want.value !== v || want.status !== s || want.last !== l) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display({"result mismatch: expected value %h status %0d last %0b, ",
                         "got value %h status %0d last %0b"},
                        want.value, want.status, want.last, v, s, l);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals
   // -------------------------------------------------------------------------
   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [31:0]       req_tdata;   // [31:0] push_value
   logic [2:0]        req_tuser;   // [2:0] action
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [31:0]       rsp_tdata;   // [31:0] result_value
   logic [1:0]        rsp_tuser;   // [1:0] status
   logic              rsp_tlast;

   int unsigned       send_idle_pct;
   int unsigned       recv_idle_pct;
   logic              hold_armed;
   deque_scoreboard   sb;

   bounded_deque_buffer_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block wedges
   initial begin
      #400000;
      $display("tb failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Monitor: both channels sampled at the same edge the block sees them.
   // Check results before noting a new action; a result never belongs to an
   // action accepted at the same edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
         if (req_tvalid && req_tready)
            sb.note_action(req_tuser, req_tdata);
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: random ready, plus one long hold-off when armed so the output
   // register stays full and the block has to stall its input.
   // -------------------------------------------------------------------------
   initial begin : receiver
      int unsigned held;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_armed) begin
            hold_armed = 1'b0;
            rsp_tready <= 1'b0;
            held = 0;
            while (held < HOLD_CYCLES) begin
               @(posedge clock);
               held++;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Sender helpers
   // -------------------------------------------------------------------------
   // Offer one action; idle first at random, then hold it until the transfer.
   // Called at a rising edge, returns at the edge of the transfer.
   task automatic offer_action(input logic [bdq_pkg::ACT_W-1:0] act, input logic [31:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= v;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Push value: mostly random, sometimes an extreme of the signed or unsigned range
   function automatic logic [31:0] random_value();
      case ($urandom_range(9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [bdq_pkg::ACT_W-1:0] pick_action(mix_type mix);
      int unsigned               w [7];
      logic [bdq_pkg::ACT_W-1:0] codes [7];
      int unsigned               r;
      codes = '{bdq_pkg::ACT_EMPTY_QUERY, bdq_pkg::ACT_PEEK_FRONT, bdq_pkg::ACT_POP_FRONT,
                bdq_pkg::ACT_PUSH_FRONT, bdq_pkg::ACT_DUMP_ALL, bdq_pkg::ACT_PUSH_BACK,
                ACT_SPARE_LO};
      case (mix)
         MIX_FILLING:  w = '{5, 5, 8, 35, 7, 37, 3};
         MIX_DRAINING: w = '{8, 10, 55, 9, 7, 8, 3};
         default:      w = '{10, 12, 20, 22, 10, 23, 3};
      endcase
      r = $urandom_range(99);
      for (int i = 0; i < 6; i++) begin
         if (r < w[i])
            return codes[i];
         r -= w[i];
      end
      return $urandom_range(1) ? ACT_SPARE_HI : ACT_SPARE_LO;
   endfunction

   // Run of random actions; ignored codes do not count towards n
   task automatic random_run(input int unsigned n, input mix_type mix);
      int unsigned               sent;
      logic [bdq_pkg::ACT_W-1:0] act;
      sent = 0;
      while (sent < n) begin
         act = pick_action(mix);
         offer_action(act, random_value());
         if (act <= bdq_pkg::ACT_PUSH_BACK)
            sent++;
      end
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      sb            = new();
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = bdq_pkg::ACT_EMPTY_QUERY;
      hold_armed    = 1'b0;
      send_idle_pct = 17;
      recv_idle_pct = 80;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Phase one: sender idles a little, receiver a lot.
      // Every query and read action on an empty store first, then the ignored codes.
      offer_action(bdq_pkg::ACT_EMPTY_QUERY, $urandom());
      offer_action(bdq_pkg::ACT_PEEK_FRONT, $urandom());
      offer_action(bdq_pkg::ACT_POP_FRONT, $urandom());
      offer_action(bdq_pkg::ACT_DUMP_ALL, $urandom());
      offer_action(ACT_SPARE_LO, $urandom());
      offer_action(ACT_SPARE_HI, $urandom());
      // Extremes from both ends; the first front push wraps the front pointer
      offer_action(bdq_pkg::ACT_PUSH_BACK, 32'h7FFF_FFFF);
      offer_action(bdq_pkg::ACT_PUSH_FRONT, 32'h8000_0000);
      offer_action(bdq_pkg::ACT_PUSH_BACK, 32'hFFFF_FFFF);
      offer_action(bdq_pkg::ACT_PUSH_FRONT, 32'h0000_0000);
      offer_action(bdq_pkg::ACT_EMPTY_QUERY, $urandom());
      offer_action(bdq_pkg::ACT_PEEK_FRONT, $urandom());
      offer_action(bdq_pkg::ACT_DUMP_ALL, $urandom());
      offer_action(bdq_pkg::ACT_POP_FRONT, $urandom());
      offer_action(bdq_pkg::ACT_POP_FRONT, $urandom());
      offer_action(bdq_pkg::ACT_PEEK_FRONT, $urandom());
      offer_action(bdq_pkg::ACT_PUSH_BACK, 32'hAAAA_AAAA);
      offer_action(bdq_pkg::ACT_PUSH_FRONT, 32'h5555_5555);
      offer_action(bdq_pkg::ACT_DUMP_ALL, $urandom());

      // Fill past the top so pushes get refused, dump the full ring, then
      // drain past the bottom
      repeat (bdq_pkg::DEPTH + 3)
         offer_action($urandom_range(1) ? bdq_pkg::ACT_PUSH_FRONT : bdq_pkg::ACT_PUSH_BACK,
                      random_value());
      offer_action(bdq_pkg::ACT_DUMP_ALL, $urandom());
      repeat (bdq_pkg::DEPTH + 2)
         offer_action(bdq_pkg::ACT_POP_FRONT, $urandom());
      random_run(4, MIX_BALANCED);

      // Phase two: roles swapped
      send_idle_pct = 80;
      recv_idle_pct = 17;
      random_run(6, MIX_FILLING);
      random_run(6, MIX_DRAINING);

      // Phase three: no idling, but the receiver holds off for a long stretch
      // while actions keep coming; open with queries so the output register
      // fills and the input stalls for certain
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_armed    = 1'b1;
      repeat (3)
         offer_action(bdq_pkg::ACT_EMPTY_QUERY, $urandom());
      random_run(18, MIX_FILLING);
      req_tvalid <= 1'b0;

      // Wait for outstanding results, then let any late transfer show up
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d actions and %0d results: %0d dumps,",
               sb.actions_seen, sb.results_seen, sb.dumps);
      $display("%0d empty answers, %0d refused pushes; mismatches %0d, outstanding %0d",
               sb.empty_answers, sb.full_answers, sb.mismatches, sb.pending.size());
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

// ===== bounded_deque_buffer_unit.f =====
rtl/bdq_pkg.sv
rtl/bdq_mem.sv
rtl/bdq_ctrl.sv
rtl/bounded_deque_buffer_unit.sv
bench/tb.sv
